@@ sv/bspq_pkg.sv @@
// Shared types and constants for the bounded stable priority queue.
// Used by the controller, the datapath, the top level and the checker.
package bspq_pkg;

    localparam int CAP_W    = 5;
    localparam int STATUS_W = 2;

    // Operation codes of a request.
    localparam logic OP_ENQ = 1'b0;
    localparam logic OP_DEQ = 1'b1;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    typedef logic [STATUS_W-1:0] t_status;

    // Controller to datapath.
    typedef struct packed {
        logic    load;    // capture a result into the output register
        logic    enq;     // insert the request's entry into the sorted row
        logic    deq;     // remove the head and shift the row up
        t_status status;
    } t_dp_cmd;

    // Datapath to controller.
    typedef struct packed {
        logic at_limit;   // count has reached the effective capacity
        logic is_zero;    // no stored entries
    } t_dp_stat;

endpackage

@@ sv/bspq_ctrl.sv @@
// Controller of the priority queue: request handshake, output register
// occupancy and the decision between success and error. Uses bspq_pkg.
module bspq_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic              i_operation,
    output logic              o_valid,
    input  logic              i_ready,
    input  bspq_pkg::t_dp_stat i_stat,
    output bspq_pkg::t_dp_cmd  o_cmd
);
    import bspq_pkg::*;

    typedef enum logic {S_IDLE, S_HOLD} t_state;

    t_state r_state;
    t_state n_state;
    logic   w_accept;

    // A new request may enter whenever the held result leaves in the same cycle.
    assign o_ready  = (r_state == S_IDLE) || i_ready;
    assign w_accept = i_valid && o_ready;
    assign o_valid  = (r_state == S_HOLD);

    always_comb begin
        o_cmd      = '0;
        o_cmd.load = w_accept;
        if (i_operation == OP_ENQ) begin
            o_cmd.enq    = w_accept && !i_stat.at_limit;
            o_cmd.status = i_stat.at_limit ? ST_FULL : ST_OK;
        end else begin
            o_cmd.deq    = w_accept && !i_stat.is_zero;
            o_cmd.status = i_stat.is_zero ? ST_EMPTY : ST_OK;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) n_state = S_HOLD;
            end
            S_HOLD: begin
                if (!w_accept && i_ready) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

@@ sv/bspq_dp.sv @@
// Datapath of the priority queue: the sorted row of entries, the count,
// the capacity register and the output register. Uses bspq_pkg.
module bspq_dp #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32,
    parameter int PRIO_WIDTH = 8,
    parameter int CNT_W      = $clog2(DEPTH + 1)
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [bspq_pkg::CAP_W-1:0] i_cfg_wdata,
    input  logic [DATA_WIDTH-1:0]    i_item_value,
    input  logic [PRIO_WIDTH-1:0]    i_item_priority,
    input  bspq_pkg::t_dp_cmd        i_cmd,
    output bspq_pkg::t_dp_stat       o_stat,
    output logic [DATA_WIDTH-1:0]    o_head_value,
    output bspq_pkg::t_status        o_status,
    output logic [CNT_W-1:0]         o_entry_count,
    output logic                     o_is_empty
);
    import bspq_pkg::*;

    localparam int LIM_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

    logic [DATA_WIDTH-1:0] r_val [DEPTH];
    logic [PRIO_WIDTH-1:0] r_pri [DEPTH];
    logic [CNT_W-1:0]      r_count;
    logic [CNT_W-1:0]      n_count;
    logic [CAP_W-1:0]      r_cap;
    logic [LIM_W-1:0]      w_cap_ext;
    logic [LIM_W-1:0]      w_limit;
    logic [DEPTH-1:0]      w_stay;

    logic [DATA_WIDTH-1:0] r_head;
    t_status               r_status;
    logic [CNT_W-1:0]      r_cnt_out;
    logic                  r_empty_out;

    assign w_cap_ext = LIM_W'(r_cap);
    assign w_limit   = (w_cap_ext > LIM_W'(DEPTH)) ? LIM_W'(DEPTH) : w_cap_ext;

    assign o_stat.at_limit = (LIM_W'(r_count) >= w_limit);
    assign o_stat.is_zero  = (r_count == '0);

    always_comb begin
        n_count = r_count;
        if (i_cmd.enq) begin
            n_count = r_count + CNT_W'(1);
        end else if (i_cmd.deq) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    // An occupied slot whose priority is at least the new one keeps its entry;
    // the row is sorted, so these slots form a prefix and the new entry lands
    // on the first slot outside it.
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        assign w_stay[g] = (CNT_W'(g) < r_count) && (r_pri[g] >= i_item_priority);

        always_ff @(posedge i_clk) begin
            if (i_cmd.enq && !w_stay[g]) begin
                if (g == 0) begin
                    r_val[g] <= i_item_value;
                    r_pri[g] <= i_item_priority;
                end else begin
                    if (w_stay[(g == 0) ? 0 : g - 1]) begin
                        r_val[g] <= i_item_value;
                        r_pri[g] <= i_item_priority;
                    end else begin
                        r_val[g] <= r_val[(g == 0) ? 0 : g - 1];
                        r_pri[g] <= r_pri[(g == 0) ? 0 : g - 1];
                    end
                end
            end else if (i_cmd.deq && (g < DEPTH - 1)) begin
                r_val[g] <= r_val[(g < DEPTH - 1) ? g + 1 : g];
                r_pri[g] <= r_pri[(g < DEPTH - 1) ? g + 1 : g];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_cap   <= CAP_RESET;
        end else begin
            r_count <= n_count;
            if (i_cfg_we) r_cap <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_head      <= i_cmd.deq ? r_val[0] : '0;
            r_status    <= i_cmd.status;
            r_cnt_out   <= n_count;
            r_empty_out <= (n_count == '0);
        end
    end

    assign o_head_value  = r_head;
    assign o_status      = r_status;
    assign o_entry_count = r_cnt_out;
    assign o_is_empty    = r_empty_out;

endmodule

@@ sv/bounded_stable_priority_queue_core.sv @@
// Top level of the bounded stable priority queue.
// Instantiates bspq_ctrl and bspq_dp; uses bspq_pkg.
//
// Usage:
//   Requests arrive on i_valid/o_ready with i_operation (enqueue or dequeue),
//   i_item_value and i_item_priority. Each request yields exactly one result
//   on o_valid/i_ready carrying o_head_value, o_status, o_entry_count and
//   o_is_empty. Entries of equal priority leave in arrival order.
//   The capacity register is written through i_cfg_we/i_cfg_wdata at any
//   edge with the write enable high; values above DEPTH act as DEPTH.
//   Latency: the result is valid in the cycle after the request is taken.
//   Throughput: one request per cycle while i_ready is high. The entries
//   sit in a row of registers that shifts by one slot, with every slot
//   comparing its priority against the incoming one in parallel.
//   Stall: the result stays in the output register until taken; o_ready
//   stays high while that register is empty or is drained in the same cycle.
//   Reset: synchronous, active low. The queue is emptied, the output
//   register is released and the capacity returns to 16. Stored entries
//   are not cleared; only occupied slots are ever read.
module bounded_stable_priority_queue_core #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32,
    parameter int PRIO_WIDTH = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic                          i_operation,
    input  logic [DATA_WIDTH-1:0]         i_item_value,
    input  logic [PRIO_WIDTH-1:0]         i_item_priority,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [DATA_WIDTH-1:0]         o_head_value,
    output logic [bspq_pkg::STATUS_W-1:0] o_status,
    output logic [$clog2(DEPTH + 1)-1:0]  o_entry_count,
    output logic                          o_is_empty,
    input  logic                          i_cfg_we,
    input  logic [bspq_pkg::CAP_W-1:0]    i_cfg_wdata
);
    import bspq_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    bspq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_operation (i_operation),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    bspq_dp #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH),
        .PRIO_WIDTH (PRIO_WIDTH),
        .CNT_W      (CNT_W)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_item_value    (i_item_value),
        .i_item_priority (i_item_priority),
        .i_cmd           (w_cmd),
        .o_stat          (w_stat),
        .o_head_value    (o_head_value),
        .o_status        (o_status),
        .o_entry_count   (o_entry_count),
        .o_is_empty      (o_is_empty)
    );

endmodule

@@ sv/bspq_checker.sv @@
// Port-level checks for the bounded stable priority queue, bound to the
// top level. Uses bspq_pkg for the status codes.
module bspq_checker #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          o_valid,
    input logic                          i_ready,
    input logic [DATA_WIDTH-1:0]         o_head_value,
    input logic [bspq_pkg::STATUS_W-1:0] o_status,
    input logic [$clog2(DEPTH + 1)-1:0]  o_entry_count,
    input logic                          o_is_empty
);
    import bspq_pkg::*;

    // A result that is not taken must be held unchanged.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_head_value)
            && $stable(o_status) && $stable(o_entry_count))
        else $error("result changed while stalled");

    // The empty flag must agree with the reported count.
    a_empty_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_is_empty == (o_entry_count == '0)))
        else $error("empty flag disagrees with count");

    // An empty error only happens on an empty queue and returns no value.
    a_empty_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == ST_EMPTY) |-> o_is_empty && (o_head_value == '0))
        else $error("empty error with entries or a value");

    // Reset releases the output register.
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

endmodule

bind bounded_stable_priority_queue_core bspq_checker #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
) u_bspq_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_valid       (o_valid),
    .i_ready       (i_ready),
    .o_head_value  (o_head_value),
    .o_status      (o_status),
    .o_entry_count (o_entry_count),
    .o_is_empty    (o_is_empty)
);
